@@ hdl/isq_pkg.sv @@
// isq_pkg: shared types and codes for the indexed sequence store
// holds command and result structs, action and status codes, controller states
// no dependencies
`timescale 1ns / 1ps

package isq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_READ       = 3'd3,
        ACT_WRITE      = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_DRAIN,
        S_HEAD,
        S_READ
    } t_state;

    typedef struct packed {
        logic [2:0]               action;
        logic [7:0]               position;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [8:0]               length;
        logic [1:0]               status;
    } t_result;

endpackage

@@ hdl/isq_mem.sv @@
// isq_mem: element storage, one write port and one registered read port
// depends on isq_pkg for the data width
`timescale 1ns / 1ps

module isq_mem #(
    parameter int DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic signed [isq_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    output logic signed [isq_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [isq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [isq_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/isq_ctrl.sv @@
// isq_ctrl: operation sequencer, element count and result register
// drives the isq_mem ports; depends on isq_pkg
`timescale 1ns / 1ps

module isq_ctrl #(
    parameter int CAPACITY = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  isq_pkg::t_cmd                         i_cmd,
    output logic                                  o_valid,
    output isq_pkg::t_result                      o_result,
    output logic                                  o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]           o_wr_addr,
    output logic signed [isq_pkg::DATA_W-1:0]     o_wr_data,
    output logic                                  o_rd_en,
    output logic [$clog2(CAPACITY)-1:0]           o_rd_addr,
    input  logic signed [isq_pkg::DATA_W-1:0]     i_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    isq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [2:0]      r_op, n_op;
    logic signed [isq_pkg::DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_waddr, n_waddr;
    logic            r_pend, n_pend;
    logic            r_valid, n_valid;
    isq_pkg::t_result r_result, n_result;

    logic                              full;
    logic                              pos_bad;
    logic                              pos_last;
    logic                              idx_last;
    logic                              is_front;
    logic                              fin;
    logic [1:0]                        fin_status;
    logic signed [isq_pkg::DATA_W-1:0] fin_rd;

    // decode against the current length
    assign full     = (r_count == CW'(CAPACITY));
    assign pos_bad  = ({{CW{1'b0}}, i_cmd.position} >= {8'd0, r_count});
    assign pos_last = (({{CW{1'b0}}, i_cmd.position} + (CW + 8)'(1)) == {8'd0, r_count});
    assign idx_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign is_front = (r_op == isq_pkg::ACT_PUSH_FRONT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            isq_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.action)
                        isq_pkg::ACT_PUSH_FRONT: begin
                            if (!full && (r_count != '0)) n_state = isq_pkg::S_MOVE;
                        end
                        isq_pkg::ACT_REMOVE: begin
                            if (!pos_bad && !pos_last) n_state = isq_pkg::S_MOVE;
                        end
                        isq_pkg::ACT_READ: begin
                            if (!pos_bad) n_state = isq_pkg::S_READ;
                        end
                        default: n_state = isq_pkg::S_IDLE;
                    endcase
                end
            end
            isq_pkg::S_MOVE: begin
                if (is_front ? (r_idx == '0) : idx_last) n_state = isq_pkg::S_DRAIN;
            end
            isq_pkg::S_DRAIN: n_state = is_front ? isq_pkg::S_HEAD : isq_pkg::S_IDLE;
            isq_pkg::S_HEAD:  n_state = isq_pkg::S_IDLE;
            isq_pkg::S_READ:  n_state = isq_pkg::S_IDLE;
            default:          n_state = isq_pkg::S_IDLE;
        endcase
    end

    // memory requests and register updates
    always_comb begin
        n_count    = r_count;
        n_op       = r_op;
        n_val      = r_val;
        n_idx      = r_idx;
        n_waddr    = r_waddr;
        n_pend     = r_pend;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_waddr;
        o_wr_data  = i_rd_data;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx;
        fin        = 1'b0;
        fin_status = isq_pkg::STAT_OK;
        fin_rd     = '0;
        case (r_state)
            isq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op  = i_cmd.action;
                    n_val = i_cmd.value;
                    case (i_cmd.action)
                        isq_pkg::ACT_PUSH_FRONT: begin
                            if (full) begin
                                fin        = 1'b1;
                                fin_status = isq_pkg::STAT_FULL;
                            end else if (r_count == '0) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = '0;
                                o_wr_data = i_cmd.value;
                                n_count   = r_count + CW'(1);
                                fin       = 1'b1;
                            end else begin
                                n_idx  = AW'(r_count - CW'(1));
                                n_pend = 1'b0;
                            end
                        end
                        isq_pkg::ACT_PUSH_BACK: begin
                            fin = 1'b1;
                            if (full) begin
                                fin_status = isq_pkg::STAT_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(r_count);
                                o_wr_data = i_cmd.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        isq_pkg::ACT_REMOVE: begin
                            if (pos_bad) begin
                                fin        = 1'b1;
                                fin_status = isq_pkg::STAT_RANGE;
                            end else if (pos_last) begin
                                n_count = r_count - CW'(1);
                                fin     = 1'b1;
                            end else begin
                                n_idx  = AW'(i_cmd.position) + AW'(1);
                                n_pend = 1'b0;
                            end
                        end
                        isq_pkg::ACT_READ: begin
                            if (pos_bad) begin
                                fin        = 1'b1;
                                fin_status = isq_pkg::STAT_RANGE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(i_cmd.position);
                            end
                        end
                        isq_pkg::ACT_WRITE: begin
                            fin = 1'b1;
                            if (pos_bad) begin
                                fin_status = isq_pkg::STAT_RANGE;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(i_cmd.position);
                                o_wr_data = i_cmd.value;
                            end
                        end
                        isq_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            fin     = 1'b1;
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            isq_pkg::S_MOVE: begin
                // read one entry, write back the one fetched last cycle
                o_rd_en = 1'b1;
                o_wr_en = r_pend;
                n_pend  = 1'b1;
                if (is_front) begin
                    n_waddr = r_idx + AW'(1);
                    n_idx   = r_idx - AW'(1);
                end else begin
                    n_waddr = r_idx - AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            isq_pkg::S_DRAIN: begin
                o_wr_en = 1'b1;
                if (!is_front) begin
                    n_count = r_count - CW'(1);
                    fin     = 1'b1;
                end
            end
            isq_pkg::S_HEAD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = r_val;
                n_count   = r_count + CW'(1);
                fin       = 1'b1;
            end
            isq_pkg::S_READ: begin
                fin    = 1'b1;
                fin_rd = i_rd_data;
            end
            default: fin = 1'b0;
        endcase
        n_valid             = fin;
        n_result.read_value = fin_rd;
        n_result.length     = 9'(n_count);
        n_result.status     = fin_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isq_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_waddr  <= n_waddr;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != isq_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("read and write of the same entry in one cycle");

    a_start_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted command neither busy nor finished");

    a_length_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.length == 9'(r_count)))
        else $error("reported length differs from element count");
`endif

endmodule

@@ hdl/indexed_sequence_store.sv @@
// indexed_sequence_store: top level of the bounded ordered sequence store
// instantiates isq_ctrl and isq_mem; depends on isq_pkg
`timescale 1ns / 1ps

// Keeps an ordered sequence of up to CAPACITY signed 32-bit elements in one
// single-port-write, registered-read memory. A command is taken at a rising
// edge where start is high and busy is low; exactly one result follows, shown
// for a single cycle with o_valid high, and the receiver has no way to hold it
// off, so it must capture every transfer. Push back, write, clear, error cases,
// unused action codes, push front into an empty store and removal of the last
// element finish at once (result the cycle after the transfer, busy never
// rises). Read passes through S_READ to collect the registered memory read.
// Push front shifts every element up one place through the memory, one entry
// per cycle, then S_DRAIN writes the last fetched entry and S_HEAD puts the new
// value at index 0. Remove shifts the elements behind the position down. The
// worst case is set by the single memory read port walking the stored entries.
// Entries never written are never read, so no clearing pass is needed after
// reset. The length field carries the count masked to 9 bits.
module indexed_sequence_store #(
    parameter int CAPACITY = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  isq_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    output isq_pkg::t_result o_result
);

    localparam int AW = $clog2(CAPACITY);

    // memory port signals between sequencer and storage
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [isq_pkg::DATA_W-1:0] wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [isq_pkg::DATA_W-1:0] rd_data;

    // sequencer: decodes commands, runs the shift walks, owns the length
    isq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_cmd     (i_cmd),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // element storage, entry k holds the element at index k
    isq_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
